### rtl/core/ftws_pkg.sv
package ftws_pkg;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam int CFG_W  = 23;
  localparam int CNT_W  = 24;
  localparam int FSUM_W = 25;
  localparam int PROD_W = 52;
  localparam int DEN_W  = 25;
  localparam int WLEN_W = 24;
  localparam int FPS_W  = 28;
  localparam int MEAN_W = 23;
  localparam int OUT_W  = 192;
  localparam int USER_W = 2;

  localparam logic [CFG_W-1:0]  INTERVAL_RST  = 23'd500000;
  localparam logic [CFG_W-1:0]  THRESH_RST    = 23'd1000000;
  localparam logic [CFG_W-1:0]  MIN_INTERVAL  = 23'd1000;
  localparam logic [FSUM_W-1:0] PUBLISH_SLACK = 25'd100;
  localparam logic [FPS_W-1:0]  FPS_SCALE     = 28'd256000000;

  typedef enum logic [0:0] {
    REG_INTERVAL = 1'b0,
    REG_THRESH   = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_CHECK,
    ST_MULT,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_PUBLISH
  } state_t;

  typedef enum logic [2:0] {
    OP_FPS,
    OP_FMEAN,
    OP_CPU,
    OP_GMAIN,
    OP_GSHADOW
  } div_op_t;

  typedef struct packed {
    logic [CFG_W-1:0] interval;
    logic [CFG_W-1:0] thresh;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic update;
    logic clear;
  } acc_ctl_t;

  typedef struct packed {
    logic ignore;
    logic pause;
    logic publish;
  } acc_stat_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### rtl/core/ftws_cfg.sv
module ftws_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ftws_pkg::APB_AW-1:0] paddr,
  input  logic [ftws_pkg::APB_DW-1:0] pwdata,
  output logic [ftws_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output ftws_pkg::cfg_t              cfg
);
  import ftws_pkg::*;

  logic [CFG_W-1:0] publish_interval;
  logic [CFG_W-1:0] pause_threshold;
  logic [CFG_W-1:0] interval_eff;
  reg_idx_t         reg_idx;

  assign reg_idx = reg_idx_t'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      publish_interval <= INTERVAL_RST;
      pause_threshold  <= THRESH_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_INTERVAL: publish_interval <= pwdata[CFG_W-1:0];
        REG_THRESH:   pause_threshold  <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_INTERVAL: prdata = APB_DW'(publish_interval);
      REG_THRESH:   prdata = APB_DW'(pause_threshold);
      default:      prdata = '0;
    endcase
  end

  assign interval_eff = (publish_interval < MIN_INTERVAL) ? MIN_INTERVAL : publish_interval;
  assign cfg.interval = interval_eff;
  assign cfg.thresh   = (pause_threshold < interval_eff) ? interval_eff : pause_threshold;

endmodule

### rtl/core/ftws_div.sv
module ftws_div #(
  parameter int NUM_W = 52,
  parameter int DEN_W = 25
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [NUM_W-1:0]      num,
  input  logic [DEN_W-1:0]      den,
  output logic [NUM_W-1:0]      quo,
  output ftws_pkg::div_stat_t   stat
);
  import ftws_pkg::*;

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  work;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den_q;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic              done;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              ge;

  // one quotient bit per cycle, restoring
  assign trial = {rem, work[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work  <= num;
      den_q <= den;
      rem   <= '0;
    end else if (busy) begin
      work <= {work[NUM_W-2:0], ge};
      rem  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign quo       = work;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

### rtl/core/ftws_acc.sv
module ftws_acc #(
  parameter int TIME_BITS = 24,
  localparam int IN_W  = ((4 * TIME_BITS + 7) / 8) * 8,
  localparam int SUM_W = TIME_BITS + 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ftws_pkg::acc_ctl_t            ctl,
  input  ftws_pkg::cfg_t                cfg,
  input  logic [IN_W-1:0]               tdata,
  input  logic [ftws_pkg::USER_W-1:0]   tuser,
  output ftws_pkg::acc_stat_t           stat,
  output logic [ftws_pkg::FSUM_W-1:0]   frame_sum,
  output logic [ftws_pkg::CFG_W-1:0]    frame_max,
  output logic [ftws_pkg::CNT_W-1:0]    frame_count,
  output logic [SUM_W-1:0]              cpu_sum,
  output logic [SUM_W-1:0]              gm_sum,
  output logic [ftws_pkg::CNT_W-1:0]    gm_count,
  output logic [SUM_W-1:0]              gs_sum,
  output logic [ftws_pkg::CNT_W-1:0]    gs_count
);
  import ftws_pkg::*;

  localparam int CW = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

  logic [TIME_BITS-1:0] ft;
  logic [TIME_BITS-1:0] ct;
  logic [TIME_BITS-1:0] gm;
  logic [TIME_BITS-1:0] gs;
  logic                 gm_present;
  logic                 gs_present;
  logic [CFG_W-1:0]     f;
  logic                 ct_pos;
  logic                 gm_take;
  logic                 gs_take;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      ft         <= tdata[TIME_BITS-1:0];
      ct         <= tdata[2*TIME_BITS-1:TIME_BITS];
      gm         <= tdata[3*TIME_BITS-1:2*TIME_BITS];
      gs         <= tdata[4*TIME_BITS-1:3*TIME_BITS];
      gm_present <= tuser[0];
      gs_present <= tuser[1];
    end
  end

  assign stat.ignore  = ft[TIME_BITS-1] || (ft == '0);
  assign stat.pause   = CW'(ft) >= CW'(cfg.thresh);
  assign stat.publish = ({1'b0, frame_sum} + {1'b0, PUBLISH_SLACK})
                        >= (FSUM_W + 1)'(cfg.interval);

  // below threshold, so the frame fits the register width
  assign f       = CFG_W'(ft);
  assign ct_pos  = !ct[TIME_BITS-1] && (ct != '0);
  assign gm_take = gm_present && !gm[TIME_BITS-1];
  assign gs_take = gs_present && !gs[TIME_BITS-1];

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      frame_sum   <= '0;
      frame_max   <= '0;
      frame_count <= '0;
      cpu_sum     <= '0;
      gm_sum      <= '0;
      gm_count    <= '0;
      gs_sum      <= '0;
      gs_count    <= '0;
    end else if (ctl.update) begin
      frame_sum   <= frame_sum + FSUM_W'(f);
      frame_count <= frame_count + 1'b1;
      if (f > frame_max) begin
        frame_max <= f;
      end
      if (ct_pos) begin
        cpu_sum <= cpu_sum + SUM_W'(ct);
      end
      if (gm_take) begin
        gm_sum   <= gm_sum + SUM_W'(gm);
        gm_count <= gm_count + 1'b1;
      end
      if (gs_take) begin
        gs_sum   <= gs_sum + SUM_W'(gs);
        gs_count <= gs_count + 1'b1;
      end
    end
  end

endmodule

### rtl/core/frame_time_window_statistics.sv
// channel   dir  handshake                 tdata (low bit up)                    tuser
// s_axis    in   s_tvalid/s_tready        frame_time, cpu_time, gpu_main_time,   main present,
//                                          gpu_shadow_time (TIME_BITS each)       shadow present
// m_axis    out  m_tvalid/m_tready        window_length, frame_total, fps,       main valid,
//                                          frame_mean, peak, cpu and gpu means,   shadow valid
// apb       in   psel/penable/pready      0x0 publish_interval, 0x4 pause_threshold
//
// After its transfer a frame passes UPDATE and CHECK before s_tready returns; an ignored or pause
// frame returns from UPDATE. A publishing frame goes on from CHECK to MULT and five bit-serial
// divisions in turn (NUM_W = max(52, TIME_BITS+24)); a gpu mean with no samples skips its division.
// rst is synchronous and clears the control state, configuration, accumulators and output valid.
// The result sits in an output register; s_tready returns while it waits, and the next
// publish waits for m_tready.
module frame_time_window_statistics #(
  parameter int TIME_BITS = 24,
  localparam int IN_W = ((4 * TIME_BITS + 7) / 8) * 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [IN_W-1:0]             s_tdata,  // frame_time, cpu_time, gpu_main_time, gpu_shadow_time
  input  logic [ftws_pkg::USER_W-1:0] s_tuser,  // gpu_main_present, gpu_shadow_present
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // window_length, frame_total, frames_per_second, frame_mean, frame_peak, cpu_mean,
  // gpu_main_mean, gpu_shadow_mean, zero pad
  output logic [ftws_pkg::OUT_W-1:0]  m_tdata,
  output logic [ftws_pkg::USER_W-1:0] m_tuser,  // gpu_main_valid, gpu_shadow_valid
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ftws_pkg::APB_AW-1:0] paddr,
  input  logic [ftws_pkg::APB_DW-1:0] pwdata,
  output logic [ftws_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import ftws_pkg::*;

  localparam int SUM_W = TIME_BITS + 24;
  localparam int NUM_W = (SUM_W > PROD_W) ? SUM_W : PROD_W;

  cfg_t              cfg;
  acc_ctl_t          acc_ctl;
  acc_stat_t         acc_stat;
  div_stat_t         div_stat;
  state_t            state, state_next;
  div_op_t           op, op_next;

  logic [FSUM_W-1:0] frame_sum;
  logic [CFG_W-1:0]  frame_max;
  logic [CNT_W-1:0]  frame_count;
  logic [SUM_W-1:0]  cpu_sum;
  logic [SUM_W-1:0]  gm_sum;
  logic [CNT_W-1:0]  gm_count;
  logic [SUM_W-1:0]  gs_sum;
  logic [CNT_W-1:0]  gs_count;

  logic              div_start;
  logic [NUM_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_den;
  logic [NUM_W-1:0]  div_quo;
  logic              op_skip;
  logic              op_store;
  logic              out_load;

  logic [PROD_W-1:0] prod;
  logic [FPS_W-1:0]  res_fps;
  logic [MEAN_W-1:0] res_fmean;
  logic [MEAN_W-1:0] res_cpu;
  logic [MEAN_W-1:0] res_gm;
  logic [MEAN_W-1:0] res_gs;

  logic [WLEN_W-1:0] out_wlen;
  logic [CNT_W-1:0]  out_count;
  logic [FPS_W-1:0]  out_fps;
  logic [MEAN_W-1:0] out_fmean;
  logic [CFG_W-1:0]  out_peak;
  logic [MEAN_W-1:0] out_cpu;
  logic [MEAN_W-1:0] out_gm;
  logic [MEAN_W-1:0] out_gs;
  logic              out_gm_valid;
  logic              out_gs_valid;
  logic              out_valid;

  ftws_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ftws_acc #(
    .TIME_BITS (TIME_BITS)
  ) u_acc (
    .clk         (clk),
    .rst         (rst),
    .ctl         (acc_ctl),
    .cfg         (cfg),
    .tdata       (s_tdata),
    .tuser       (s_tuser),
    .stat        (acc_stat),
    .frame_sum   (frame_sum),
    .frame_max   (frame_max),
    .frame_count (frame_count),
    .cpu_sum     (cpu_sum),
    .gm_sum      (gm_sum),
    .gm_count    (gm_count),
    .gs_sum      (gs_sum),
    .gs_count    (gs_count)
  );

  ftws_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  always_comb begin
    unique case (op)
      OP_FPS: begin
        div_num = NUM_W'(prod);
        div_den = DEN_W'(frame_sum);
        op_skip = 1'b0;
      end
      OP_FMEAN: begin
        div_num = NUM_W'(frame_sum);
        div_den = DEN_W'(frame_count);
        op_skip = 1'b0;
      end
      OP_CPU: begin
        div_num = NUM_W'(cpu_sum);
        div_den = DEN_W'(frame_count);
        op_skip = 1'b0;
      end
      OP_GMAIN: begin
        div_num = NUM_W'(gm_sum);
        div_den = DEN_W'(gm_count);
        op_skip = (gm_count == '0);
      end
      OP_GSHADOW: begin
        div_num = NUM_W'(gs_sum);
        div_den = DEN_W'(gs_count);
        op_skip = (gs_count == '0);
      end
      default: begin
        div_num = '0;
        div_den = '0;
        op_skip = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op    <= OP_FPS;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    acc_ctl    = '0;
    div_start  = 1'b0;
    op_store   = 1'b0;
    out_load   = 1'b0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          acc_ctl.load = 1'b1;
          state_next   = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (acc_stat.ignore) begin
          state_next = ST_IDLE;
        end else if (acc_stat.pause) begin
          acc_ctl.clear = 1'b1;
          state_next    = ST_IDLE;
        end else begin
          acc_ctl.update = 1'b1;
          state_next     = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = acc_stat.publish ? ST_MULT : ST_IDLE;
      end
      ST_MULT: begin
        op_next    = OP_FPS;
        state_next = ST_DIV_START;
      end
      ST_DIV_START: begin
        if (op_skip) begin
          op_store = 1'b1;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          op_store = 1'b1;
        end
      end
      ST_PUBLISH: begin
        if (!out_valid || m_tready) begin
          out_load      = 1'b1;
          acc_ctl.clear = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    if (op_store) begin
      unique case (op)
        OP_FPS:     op_next = OP_FMEAN;
        OP_FMEAN:   op_next = OP_CPU;
        OP_CPU:     op_next = OP_GMAIN;
        OP_GMAIN:   op_next = OP_GSHADOW;
        OP_GSHADOW: op_next = OP_FPS;
        default:    op_next = OP_FPS;
      endcase
      state_next = (op == OP_GSHADOW) ? ST_PUBLISH : ST_DIV_START;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_MULT) begin
      prod <= PROD_W'(frame_count) * PROD_W'(FPS_SCALE);
    end
    if (op_store) begin
      case (op)
        OP_FPS:     res_fps   <= div_quo[FPS_W-1:0];
        OP_FMEAN:   res_fmean <= div_quo[MEAN_W-1:0];
        OP_CPU:     res_cpu   <= div_quo[MEAN_W-1:0];
        OP_GMAIN:   res_gm    <= op_skip ? '0 : div_quo[MEAN_W-1:0];
        OP_GSHADOW: res_gs    <= op_skip ? '0 : div_quo[MEAN_W-1:0];
        default: ;
      endcase
    end
    if (out_load) begin
      out_wlen     <= frame_sum[WLEN_W-1:0];
      out_count    <= frame_count;
      out_fps      <= res_fps;
      out_fmean    <= res_fmean;
      out_peak     <= frame_max;
      out_cpu      <= res_cpu;
      out_gm       <= res_gm;
      out_gs       <= res_gs;
      out_gm_valid <= (gm_count != '0);
      out_gs_valid <= (gs_count != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_gs, out_gm, out_cpu, out_peak, out_fmean, out_fps,
                     out_count, out_wlen};
  assign m_tuser  = {out_gs_valid, out_gm_valid};

endmodule
